// ===== design/hsla_pkg.sv =====
package hsla_pkg;

    localparam int DEFAULT_FRAC_BITS = 12;
    localparam int CH_W = 8;
    localparam int DEN_W = 9;
    localparam int LANES = 3;
    localparam int LANE_SAT = 0;
    localparam int LANE_LUM = 1;
    localparam int LANE_HUE = 2;
    localparam int DEG_FULL = 360;
    localparam int DEG_TWO_THIRD = 240;
    localparam int DEG_THIRD = 120;
    localparam int DEG_SIXTH = 60;
    localparam int LUM_DEN = 510;
    localparam int LUM_SHIFT = 18;
    localparam int HALF_SUM = 255;
    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_SAT_GAIN = 2'd0;
    localparam logic [1:0] REG_LUM_GAIN = 2'd1;
    localparam logic [1:0] REG_LUM_FLOOR = 2'd2;

    typedef enum logic [1:0] {
        BASE_RED,
        BASE_GREEN,
        BASE_BLUE
    } hue_base_t;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
    } pix_out_t;

    typedef struct packed {
        pix_in_t   rgb;
        hue_base_t base;
        logic      neg;
        logic      flat;
    } hsla_side_t;

    typedef struct packed {
        logic [15:0] sat_gain;
        logic [15:0] lum_gain;
        logic [12:0] lum_floor;
    } hsla_cfg_t;

endpackage

// ===== design/hsla_front.sv =====
module hsla_front
    import hsla_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  pix_in_t                               pix,
    output logic                                  out_valid,
    output logic [LANES-1:0][FRAC_BITS+8:0]       num,
    output logic [LANES-1:0][DEN_W-1:0]           den,
    output hsla_side_t                            side
);

    localparam int NUM_W = FRAC_BITS + 9;

    logic [CH_W-1:0] r, g, b, mx, mn, mag;
    logic [DEN_W-1:0] sum;
    logic [CH_W-1:0] diff;
    hue_base_t base;
    logic neg;

    logic valid_reg;
    logic [LANES-1:0][NUM_W-1:0] num_reg, num_next;
    logic [LANES-1:0][DEN_W-1:0] den_reg, den_next;
    hsla_side_t side_reg, side_next;

    always_comb
    begin
        r = pix.red_in;
        g = pix.green_in;
        b = pix.blue_in;
        mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        sum = DEN_W'(mx) + DEN_W'(mn);
        diff = mx - mn;
        if (mx == r)
        begin
            base = BASE_RED;
            neg = g < b;
            mag = neg ? (b - g) : (g - b);
        end
        else if (mx == g)
        begin
            base = BASE_GREEN;
            neg = b < r;
            mag = neg ? (r - b) : (b - r);
        end
        else
        begin
            base = BASE_BLUE;
            neg = r < g;
            mag = neg ? (g - r) : (r - g);
        end
        num_next[LANE_SAT] = NUM_W'(diff) << FRAC_BITS;
        den_next[LANE_SAT] = (sum < DEN_W'(HALF_SUM)) ? sum : DEN_W'(LUM_DEN) - sum;
        num_next[LANE_LUM] = NUM_W'(sum);
        den_next[LANE_LUM] = DEN_W'(LUM_DEN);
        num_next[LANE_HUE] = NUM_W'(14'(mag) * 14'(DEG_SIXTH));
        den_next[LANE_HUE] = DEN_W'(diff);
        side_next.rgb = pix;
        side_next.base = base;
        side_next.neg = neg;
        side_next.flat = diff == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        side_reg <= side_next;
    end

    assign out_valid = valid_reg;
    assign num = num_reg;
    assign den = den_reg;
    assign side = side_reg;

endmodule

// ===== design/hsla_div_pipe.sv =====
module hsla_div_pipe
    import hsla_pkg::*;
#(
    parameter int NUM_W = DEFAULT_FRAC_BITS + 9,
    parameter int QUO_W = DEFAULT_FRAC_BITS + 1
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]     num,
    input  logic [LANES-1:0][DEN_W-1:0]     den,
    input  hsla_side_t                      side_in,
    output logic                            out_valid,
    output logic [LANES-1:0][QUO_W-1:0]     quo,
    output logic [LANES-1:0]                rem_nz,
    output hsla_side_t                      side_out
);

    localparam int REM_W = DEN_W;
    localparam int RCP_W = DEN_W + LUM_SHIFT + QUO_W;
    localparam longint LUM_RECIP = ((longint'(1) << (LUM_SHIFT + QUO_W - 1))
                                    + longint'(LUM_DEN - 1)) / longint'(LUM_DEN);

    logic [QUO_W-1:0] valid_reg;
    logic [LANES-1:0][REM_W-1:0] rem_reg [QUO_W];
    logic [LANES-1:0][QUO_W-1:0] low_reg [QUO_W];
    logic [LANES-1:0][QUO_W-1:0] quo_reg [QUO_W];
    logic [LANES-1:0][DEN_W-1:0] den_reg [QUO_W];
    hsla_side_t side_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_step
        logic v_src;
        logic [LANES-1:0][REM_W-1:0] rem_src, rem_next;
        logic [LANES-1:0][QUO_W-1:0] low_src, low_next, quo_src, quo_next;
        logic [LANES-1:0][DEN_W-1:0] den_src;
        hsla_side_t side_src;

        if (i == 0)
        begin : g_first
            always_comb
            begin
                v_src = in_valid;
                side_src = side_in;
                den_src = den;
                for (int l = 0; l < LANES; l++)
                begin
                    rem_src[l] = REM_W'(num[l][NUM_W-1:QUO_W]);
                    low_src[l] = num[l][QUO_W-1:0];
                    quo_src[l] = '0;
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                v_src = valid_reg[i-1];
                side_src = side_reg[i-1];
                den_src = den_reg[i-1];
                rem_src = rem_reg[i-1];
                low_src = low_reg[i-1];
                quo_src = quo_reg[i-1];
            end
        end

        always_comb
        begin
            logic [REM_W:0] trial;
            logic ge;
            logic [RCP_W-1:0] rcp;
            // luminance divides by a constant: reciprocal multiply in the first step
            rcp = RCP_W'(num[LANE_LUM][DEN_W-1:0]) * RCP_W'(LUM_RECIP);
            for (int l = 0; l < LANES; l++)
            begin
                if (l == LANE_LUM)
                begin
                    rem_next[l] = '0;
                    low_next[l] = '0;
                    quo_next[l] = (i == 0) ? rcp[LUM_SHIFT +: QUO_W] : quo_src[l];
                end
                else
                begin
                    trial = {rem_src[l], low_src[l][QUO_W-1]};
                    ge = trial >= {1'b0, den_src[l]};
                    rem_next[l] = ge ? REM_W'(trial - {1'b0, den_src[l]}) : REM_W'(trial);
                    low_next[l] = low_src[l] << 1;
                    quo_next[l] = {quo_src[l][QUO_W-2:0], ge};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= rem_next;
            low_reg[i] <= low_next;
            quo_reg[i] <= quo_next;
            den_reg[i] <= den_src;
            side_reg[i] <= side_src;
        end
    end

    always_comb
    begin
        out_valid = valid_reg[QUO_W-1];
        quo = quo_reg[QUO_W-1];
        side_out = side_reg[QUO_W-1];
        for (int l = 0; l < LANES; l++)
        begin
            rem_nz[l] = rem_reg[QUO_W-1][l] != '0;
        end
    end

endmodule

// ===== design/hsla_back.sv =====
module hsla_back
    import hsla_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [LANES-1:0][FRAC_BITS:0]     quo,
    input  logic [LANES-1:0]                  rem_nz,
    input  hsla_side_t                        side,
    input  hsla_cfg_t                         cfg,
    output logic                              done,
    output pix_out_t                          pix
);

    localparam int F = FRAC_BITS;
    localparam int ONE_W = F + 1;
    localparam int ONE_I = 1 << F;
    localparam logic [ONE_W-1:0] ONE = ONE_W'(ONE_I);
    localparam int G_W = 17;
    localparam int P_W = 2 * F + 3;
    localparam int Q_W = F + 3;
    localparam int V_W = F + 7;
    localparam int K_W = 6;

    // stage 1: gains, floor, hue
    logic [F+16:0] s_prod, l_prod;
    logic [G_W-1:0] s_scaled, l_scaled, l_f;
    logic [ONE_W-1:0] s_clip, s1_next, l1_next;
    logic floor_hit;
    logic [9:0] base_v, hq, hue_adj;
    logic [8:0] hue1_next;

    logic v1_reg;
    logic [ONE_W-1:0] s1_reg, l1_reg;
    logic [8:0] hue1_reg;
    pix_in_t rgb1_reg;

    always_comb
    begin
        s_prod = quo[LANE_SAT] * cfg.sat_gain;
        l_prod = quo[LANE_LUM] * cfg.lum_gain;
        s_scaled = s_prod[F+16:F];
        l_scaled = l_prod[F+16:F];
        s_clip = (s_scaled > G_W'(ONE_I)) ? ONE : s_scaled[ONE_W-1:0];
        floor_hit = l_scaled < G_W'(cfg.lum_floor);
        l_f = floor_hit ? G_W'(cfg.lum_floor) : l_scaled;
        l1_next = (l_f > G_W'(ONE_I)) ? ONE : l_f[ONE_W-1:0];
        s1_next = (floor_hit || side.flat) ? '0 : s_clip;
        case (side.base)
            BASE_RED:   base_v = 10'(DEG_FULL);
            BASE_GREEN: base_v = 10'(DEG_THIRD);
            BASE_BLUE:  base_v = 10'(DEG_TWO_THIRD);
            default:    base_v = '0;
        endcase
        hq = 10'(quo[LANE_HUE][8:0]);
        hue_adj = side.neg ? (base_v - hq - 10'(rem_nz[LANE_HUE])) : (base_v + hq);
        if (side.flat)
        begin
            hue1_next = '0;
        end
        else if (hue_adj >= 10'(DEG_FULL))
        begin
            hue1_next = 9'(hue_adj - 10'(DEG_FULL));
        end
        else
        begin
            hue1_next = hue_adj[8:0];
        end
    end

    // stage 2: q product, channel angles
    logic lt2_next;
    logic [ONE_W:0] mul_b;
    logic [2:0][8:0] t2_next;

    logic v2_reg, lt2_reg, grey2_reg;
    logic [P_W-1:0] prod2_reg;
    logic [ONE_W-1:0] s2_reg, l2_reg;
    logic [2:0][8:0] t2_reg;
    pix_in_t rgb2_reg;

    always_comb
    begin
        lt2_next = l1_reg < ONE_W'(ONE_I / 2);
        mul_b = lt2_next ? ((ONE_W + 1)'(ONE_I) + (ONE_W + 1)'(s1_reg)) : (ONE_W + 1)'(s1_reg);
        t2_next[0] = (hue1_reg >= 9'(DEG_FULL - DEG_THIRD)) ?
            9'(hue1_reg - 9'(DEG_FULL - DEG_THIRD)) : 9'(hue1_reg + 9'(DEG_THIRD));
        t2_next[1] = hue1_reg;
        t2_next[2] = (hue1_reg < 9'(DEG_THIRD)) ?
            9'(hue1_reg + 9'(DEG_TWO_THIRD)) : 9'(hue1_reg - 9'(DEG_THIRD));
    end

    // stage 3: q, p and per-channel slope
    logic [Q_W-1:0] ps, q_raw;
    logic [ONE_W-1:0] q3, p3_next;
    logic [ONE_W:0] two_l, pd;
    logic [2:0][K_W-1:0] k3_next;

    logic v3_reg, grey3_reg;
    logic [ONE_W-1:0] p3_reg, d3_reg, l3_reg;
    logic [2:0][K_W-1:0] k3_reg;
    pix_in_t rgb3_reg;

    always_comb
    begin
        ps = prod2_reg[P_W-1:F];
        q_raw = lt2_reg ? ps : (Q_W'(l2_reg) + Q_W'(s2_reg) - ps);
        q3 = (q_raw > Q_W'(ONE_I)) ? ONE : q_raw[ONE_W-1:0];
        two_l = {l2_reg, 1'b0};
        pd = two_l - (ONE_W + 1)'(q3);
        if (two_l < (ONE_W + 1)'(q3))
        begin
            p3_next = '0;
        end
        else if (pd > (ONE_W + 1)'(q3))
        begin
            p3_next = q3;
        end
        else
        begin
            p3_next = pd[ONE_W-1:0];
        end
        for (int c = 0; c < 3; c++)
        begin
            if (t2_reg[c] < 9'(DEG_SIXTH))
            begin
                k3_next[c] = K_W'(t2_reg[c]);
            end
            else if (t2_reg[c] < 9'(DEG_SIXTH + DEG_THIRD))
            begin
                k3_next[c] = K_W'(DEG_SIXTH);
            end
            else if (t2_reg[c] < 9'(DEG_TWO_THIRD))
            begin
                k3_next[c] = K_W'(9'(DEG_TWO_THIRD) - t2_reg[c]);
            end
            else
            begin
                k3_next[c] = '0;
            end
        end
    end

    // stage 4: channel value in sixtieths
    logic [2:0][V_W-1:0] v4_next;

    logic v4_reg, grey4_reg;
    logic [2:0][V_W-1:0] v4_reg_data;
    logic [ONE_W-1:0] l4_reg;
    pix_in_t rgb4_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            v4_next[c] = V_W'(p3_reg) * V_W'(DEG_SIXTH) + V_W'(d3_reg) * V_W'(k3_reg[c]);
        end
    end

    // stage 5: scale to 8 bits, select
    logic [V_W+4:0] ch_prod;
    logic [9:0] ch_full;
    logic [2:0][CH_W-1:0] ch;
    logic [F+8:0] grey_prod;
    logic [8:0] grey_full;
    logic [CH_W-1:0] grey_v;
    logic bypass;
    pix_out_t pix_next;

    logic done_reg;
    pix_out_t pix_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ch_prod = (V_W + 5)'(v4_reg_data[c]) * (V_W + 5)'(17);
            ch_full = ch_prod[V_W+4:F+2];
            ch[c] = (ch_full > 10'(255)) ? 8'hff : ch_full[CH_W-1:0];
        end
        grey_prod = (F + 9)'(l4_reg) * (F + 9)'(255);
        grey_full = grey_prod[F+8:F];
        grey_v = (grey_full > 9'(255)) ? 8'hff : grey_full[CH_W-1:0];
        bypass = ({1'b0, cfg.sat_gain} == G_W'(ONE_I)) &&
                 ({1'b0, cfg.lum_gain} == G_W'(ONE_I)) &&
                 (cfg.lum_floor == '0);
        if (bypass)
        begin
            pix_next.red_out = rgb4_reg.red_in;
            pix_next.green_out = rgb4_reg.green_in;
            pix_next.blue_out = rgb4_reg.blue_in;
        end
        else if (grey4_reg)
        begin
            pix_next.red_out = grey_v;
            pix_next.green_out = grey_v;
            pix_next.blue_out = grey_v;
        end
        else
        begin
            pix_next.red_out = ch[0];
            pix_next.green_out = ch[1];
            pix_next.blue_out = ch[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        l1_reg <= l1_next;
        hue1_reg <= hue1_next;
        rgb1_reg <= side.rgb;

        prod2_reg <= P_W'(l1_reg) * P_W'(mul_b);
        lt2_reg <= lt2_next;
        grey2_reg <= s1_reg == '0;
        s2_reg <= s1_reg;
        l2_reg <= l1_reg;
        t2_reg <= t2_next;
        rgb2_reg <= rgb1_reg;

        p3_reg <= p3_next;
        d3_reg <= q3 - p3_next;
        k3_reg <= k3_next;
        l3_reg <= l2_reg;
        grey3_reg <= grey2_reg;
        rgb3_reg <= rgb2_reg;

        v4_reg_data <= v4_next;
        l4_reg <= l3_reg;
        grey4_reg <= grey3_reg;
        rgb4_reg <= rgb3_reg;

        pix_reg <= pix_next;
    end

    assign done = done_reg;
    assign pix = pix_reg;

endmodule

// ===== design/hsl_saturation_luminance_adjust.sv =====
// throughput: one item per cycle, busy is always low
// the depth is set by the bit-per-stage divider for saturation and hue
// results show on done for one cycle; the receiver cannot stall them
// reset clears all valid bits and loads unity gains and a zero floor
module hsl_saturation_luminance_adjust
    import hsla_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pix_in_t              pix_in,
    output logic                 done,
    output pix_out_t             pix_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int F = GAIN_FRAC_BITS;
    localparam int NUM_W = F + 9;
    localparam int QUO_W = F + 1;
    localparam int ONE_I = 1 << F;

    hsla_cfg_t cfg_reg;
    logic wr_en;

    logic f_valid, d_valid;
    logic [LANES-1:0][NUM_W-1:0] f_num;
    logic [LANES-1:0][DEN_W-1:0] f_den;
    hsla_side_t f_side, d_side;
    logic [LANES-1:0][QUO_W-1:0] d_quo;
    logic [LANES-1:0] d_rem_nz;

    assign pready = 1'b1;
    assign busy = 1'b0;
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sat_gain <= 16'(ONE_I);
            cfg_reg.lum_gain <= 16'(ONE_I);
            cfg_reg.lum_floor <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_SAT_GAIN:  cfg_reg.sat_gain <= pwdata[15:0];
                REG_LUM_GAIN:  cfg_reg.lum_gain <= pwdata[15:0];
                REG_LUM_FLOOR: cfg_reg.lum_floor <= pwdata[12:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SAT_GAIN:  prdata = 32'(cfg_reg.sat_gain);
            REG_LUM_GAIN:  prdata = 32'(cfg_reg.lum_gain);
            REG_LUM_FLOOR: prdata = 32'(cfg_reg.lum_floor);
            default:       prdata = '0;
        endcase
    end

    hsla_front #(.FRAC_BITS(F)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .pix       (pix_in),
        .out_valid (f_valid),
        .num       (f_num),
        .den       (f_den),
        .side      (f_side)
    );

    hsla_div_pipe #(.NUM_W(NUM_W), .QUO_W(QUO_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .num       (f_num),
        .den       (f_den),
        .side_in   (f_side),
        .out_valid (d_valid),
        .quo       (d_quo),
        .rem_nz    (d_rem_nz),
        .side_out  (d_side)
    );

    hsla_back #(.FRAC_BITS(F)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (d_valid),
        .quo      (d_quo),
        .rem_nz   (d_rem_nz),
        .side     (d_side),
        .cfg      (cfg_reg),
        .done     (done),
        .pix      (pix_out)
    );

endmodule

// ===== design/hsla_checker.sv =====
module hsla_checker
    import hsla_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic                pready
);

    localparam int LAT = FRAC_BITS + 7;

    // every accepted item comes out after the fixed latency
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("item not delivered on time");

    // no result without an item accepted the latency before
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without item");

    a_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && pready)
        else $error("block not ready");

endmodule

bind hsl_saturation_luminance_adjust hsla_checker #(.FRAC_BITS(GAIN_FRAC_BITS)) u_hsla_checker (.*);
